// File: hdl/aes_pkg.sv
`timescale 1ns / 1ps
package aes_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_ENCRYPT = 2'd1,
    CMD_DECRYPT = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_FETCH = 2'd1,
    ST_ROUND = 2'd2,
    ST_OUT   = 2'd3
  } state_t;

  localparam logic [3:0] MIN_ROUNDS = 4'd10;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] x;
    logic [7:0] acc;
    x = a;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ x;
      x = xtime(x);
    end
    gf_mul = acc;
  endfunction

  function automatic logic [7:0] gf_inv(input logic [7:0] x);
    logic [7:0] p;
    logic [7:0] r;
    p = x;
    r = 8'h01;
    for (int i = 0; i < 7; i++) begin
      p = gf_mul(p, p);
      r = gf_mul(r, p);
    end
    gf_inv = r;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
    rotl8 = (x << n) | (x >> (8 - n));
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] x);
    logic [7:0] b;
    b = gf_inv(x);
    sbox_calc = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] inv_sbox_calc(input logic [7:0] x);
    inv_sbox_calc = gf_inv(rotl8(x, 1) ^ rotl8(x, 3) ^ rotl8(x, 6) ^ 8'h05);
  endfunction

  typedef logic [7:0] sbox_arr_t [256];

  function automatic sbox_arr_t mk_sbox(input logic inv);
    sbox_arr_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = inv ? inv_sbox_calc(8'(i)) : sbox_calc(8'(i));
    end
    mk_sbox = t;
  endfunction

  localparam sbox_arr_t SBOX     = mk_sbox(1'b0);
  localparam sbox_arr_t INV_SBOX = mk_sbox(1'b1);

endpackage

// File: hdl/aes_round.sv
`timescale 1ns / 1ps
// One cipher round over the whole state; round key arrives as four words.
module aes_round (
  input  logic [127:0] state_in,
  input  logic [127:0] rkey,
  input  logic         inverse,
  input  logic         first,
  input  logic         last,
  output logic [127:0] state_out
);
  import aes_pkg::*;

  logic [7:0] s  [16];
  logic [7:0] t  [16];
  logic [7:0] m  [16];
  logic [7:0] k  [16];
  logic [7:0] o  [16];
  logic [7:0] a0, a1, a2, a3;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_in[127 - 8*i -: 8];
      k[i] = rkey[127 - 8*i -: 8];
    end
    // sub + shift rows
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inverse) t[4*c+r] = INV_SBOX[s[4*((c - r + 4) % 4) + r]];
        else         t[4*c+r] = SBOX[s[4*((c + r) % 4) + r]];
      end
    end
    // decrypt adds key before mix, encrypt after
    for (int i = 0; i < 16; i++) m[i] = inverse ? (t[i] ^ k[i]) : t[i];
    for (int c = 0; c < 4; c++) begin
      a0 = m[4*c]; a1 = m[4*c+1]; a2 = m[4*c+2]; a3 = m[4*c+3];
      if (inverse) begin
        o[4*c]   = gf_mul(8'd14,a0)^gf_mul(8'd11,a1)^gf_mul(8'd13,a2)^gf_mul(8'd9,a3);
        o[4*c+1] = gf_mul(8'd9,a0)^gf_mul(8'd14,a1)^gf_mul(8'd11,a2)^gf_mul(8'd13,a3);
        o[4*c+2] = gf_mul(8'd13,a0)^gf_mul(8'd9,a1)^gf_mul(8'd14,a2)^gf_mul(8'd11,a3);
        o[4*c+3] = gf_mul(8'd11,a0)^gf_mul(8'd13,a1)^gf_mul(8'd9,a2)^gf_mul(8'd14,a3);
      end else begin
        o[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        o[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        o[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        o[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (first)        state_out[127 - 8*i -: 8] = s[i] ^ k[i];
      else if (last)    state_out[127 - 8*i -: 8] = m[i] ^ (inverse ? 8'h00 : k[i]);
      else if (inverse) state_out[127 - 8*i -: 8] = o[i];
      else              state_out[127 - 8*i -: 8] = o[i] ^ k[i];
    end
  end
endmodule

// File: hdl/aes_key_ram.sv
`timescale 1ns / 1ps
// Round-key store: one row of four words per round, registered read.
module aes_key_ram #(
  parameter int ROWS = 15
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [$clog2(ROWS)-1:0] waddr,
  input  logic [1:0]              wcol,
  input  logic [31:0]             wdata,
  input  logic [$clog2(ROWS)-1:0] raddr,
  output logic [127:0]            rdata
);
  logic [31:0] mem0 [ROWS];
  logic [31:0] mem1 [ROWS];
  logic [31:0] mem2 [ROWS];
  logic [31:0] mem3 [ROWS];

  always_ff @(posedge clk) begin
    if (we && wcol == 2'd0) mem0[waddr] <= wdata;
    if (we && wcol == 2'd1) mem1[waddr] <= wdata;
    if (we && wcol == 2'd2) mem2[waddr] <= wdata;
    if (we && wcol == 2'd3) mem3[waddr] <= wdata;
    rdata <= {mem0[raddr], mem1[raddr], mem2[raddr], mem3[raddr]};
  end
endmodule

// File: hdl/aes_block_cipher_core.sv
`timescale 1ns / 1ps
// Channel | Direction | Ports
// in      | input     | in_valid, in_stall, in_cmd, in_key_word_index, in_key_word_value,
//         |           | in_block_hi, in_block_lo
// out     | output    | out_valid, out_stall, out_result_hi, out_result_lo, out_was_decrypt
// cfg     | input     | cfg_we, cfg_data (round_count)
//
// A load beat leaves the core idle. Key row 0 (or row Nr for decrypt) is read on the
// accepting edge, then one round per cycle through the shared round unit (rounds 0
// to Nr, each key row read in the cycle before its round) and then into the output
// register, which raises out_valid; the next beat can be taken once the result has
// moved there. in_stall is high only while a block is in flight; a finished block
// waits in place while the previous result is still stalled. Synchronous active-low
// reset clears control only; the key memory has no reset.
module aes_block_cipher_core #(
  parameter int KEY_WORDS = 60
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [3:0]    cfg_data,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_cmd,
  input  logic [5:0]    in_key_word_index,
  input  logic [31:0]   in_key_word_value,
  input  logic [63:0]   in_block_hi,
  input  logic [63:0]   in_block_lo,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [63:0]   out_result_hi,
  output logic [63:0]   out_result_lo,
  output logic          out_was_decrypt
);
  import aes_pkg::*;

  localparam int ROWS = KEY_WORDS / 4;
  localparam int RW   = $clog2(ROWS);
  localparam logic [3:0] MAX_ROUNDS = 4'(ROWS - 1);

  state_t        state_r, state_nxt;
  logic [3:0]    round_count_r;
  logic [3:0]    nr_r, nr_nxt;
  logic [3:0]    rnd_r, rnd_nxt;
  logic          dec_r, dec_nxt;
  logic [127:0]  st_r, st_nxt;
  logic          ov_r, ov_nxt;
  logic [127:0]  res_r, res_nxt;
  logic          resdec_r, resdec_nxt;
  logic [3:0]    nr_eff;
  logic [3:0]    raddr;
  logic [127:0]  rkey;
  logic [127:0]  rnd_out;
  logic          acc;
  logic          kwe;

  assign acc = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign kwe = acc && cmd_t'(in_cmd) == CMD_LOAD && in_key_word_index < 6'(KEY_WORDS);

  always_comb begin
    nr_eff = round_count_r;
    if (nr_eff < MIN_ROUNDS) nr_eff = MIN_ROUNDS;
    if (nr_eff > MAX_ROUNDS) nr_eff = MAX_ROUNDS;
  end

  // key row for the round in the next cycle
  always_comb begin
    raddr = 4'd0;
    case (state_r)
      ST_IDLE: raddr = (cmd_t'(in_cmd) == CMD_DECRYPT) ? nr_eff : 4'd0;
      default: raddr = dec_r ? (nr_r - rnd_r - 4'd1) : (rnd_r + 4'd1);
    endcase
  end

  aes_key_ram #(.ROWS(ROWS)) u_keys (
    .clk   (clk),
    .we    (kwe),
    .waddr (RW'(in_key_word_index[5:2])),
    .wcol  (in_key_word_index[1:0]),
    .wdata (in_key_word_value),
    .raddr (RW'(raddr)),
    .rdata (rkey)
  );

  aes_round u_round (
    .state_in  (st_r),
    .rkey      (rkey),
    .inverse   (dec_r),
    .first     (rnd_r == 4'd0),
    .last      (rnd_r == nr_r),
    .state_out (rnd_out)
  );

  always_comb begin
    state_nxt = state_r;
    nr_nxt = nr_r;
    rnd_nxt = rnd_r;
    dec_nxt = dec_r;
    st_nxt = st_r;
    ov_nxt = ov_r && out_stall;
    res_nxt = res_r;
    resdec_nxt = resdec_r;
    case (state_r)
      ST_IDLE: begin
        if (acc && (cmd_t'(in_cmd) == CMD_ENCRYPT || cmd_t'(in_cmd) == CMD_DECRYPT)) begin
          state_nxt = ST_ROUND;
          nr_nxt = nr_eff;
          rnd_nxt = 4'd0;
          dec_nxt = cmd_t'(in_cmd) == CMD_DECRYPT;
          st_nxt = {in_block_hi, in_block_lo};
        end
      end
      ST_ROUND: begin
        st_nxt = rnd_out;
        rnd_nxt = rnd_r + 4'd1;
        if (rnd_r == nr_r) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // old result may leave on the same edge the new one lands
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          res_nxt = st_r;
          resdec_nxt = dec_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r <= 1'b0;
      round_count_r <= 4'd10;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      if (cfg_we) round_count_r <= cfg_data;
    end
    nr_r <= nr_nxt;
    rnd_r <= rnd_nxt;
    dec_r <= dec_nxt;
    st_r <= st_nxt;
    res_r <= res_nxt;
    resdec_r <= resdec_nxt;
  end

  assign out_valid = ov_r;
  assign out_result_hi = res_r[127:64];
  assign out_result_lo = res_r[63:0];
  assign out_was_decrypt = resdec_r;
endmodule

// File: tb/aes_cipher_checker.sv
`timescale 1ns / 1ps
module aes_cipher_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [5:0]  in_key_word_index,
  input  logic [31:0] in_key_word_value,
  input  logic [63:0] in_block_hi,
  input  logic [63:0] in_block_lo,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_result_hi,
  input  logic [63:0] out_result_lo,
  input  logic        out_was_decrypt,
  output int          errors,
  output int          pending
);
  import aes_pkg::*;

  localparam int KEY_WORDS = 60;
  localparam int MAX_ROUNDS = KEY_WORDS / 4 - 1;

  typedef logic [7:0] blk_t [16];

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        dec;
  } cipher_out_t;

  logic [31:0] key_mem [KEY_WORDS];
  logic [7:0]  fwd_sub [256];
  logic [7:0]  inv_sub [256];
  logic [3:0]  rounds;
  cipher_out_t cipher_q [$];

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [8:0] x;
    logic [7:0] acc;
    x = {1'b0, a};
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= x[7:0];
      x = x << 1;
      if (x[8]) x ^= 9'h11b;
    end
    return acc;
  endfunction

  function automatic logic [7:0] ginv(logic [7:0] x);
    logic [7:0] p;
    logic [7:0] r;
    p = x;
    r = 8'h01;
    for (int i = 0; i < 7; i++) begin
      p = gmul(p, p);
      r = gmul(r, p);
    end
    return r;
  endfunction

  function automatic logic [7:0] rol(logic [7:0] x, int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  initial begin
    logic [7:0] b;
    for (int i = 0; i < 256; i++) begin
      b = ginv(8'(i));
      fwd_sub[i] = b ^ rol(b, 1) ^ rol(b, 2) ^ rol(b, 3) ^ rol(b, 4) ^ 8'h63;
      b = 8'(i);
      inv_sub[i] = ginv(rol(b, 1) ^ rol(b, 3) ^ rol(b, 6) ^ 8'h05);
    end
  end

  function automatic blk_t add_round_key(blk_t s, int rnd);
    logic [31:0] w;
    for (int c = 0; c < 4; c++) begin
      w = key_mem[4 * rnd + c];
      s[4*c+0] ^= w[31:24];
      s[4*c+1] ^= w[23:16];
      s[4*c+2] ^= w[15:8];
      s[4*c+3] ^= w[7:0];
    end
    return s;
  endfunction

  function automatic blk_t sub_shift(blk_t s, logic inv);
    blk_t t;
    int   src;
    t = s;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? (c - r + 4) % 4 : (c + r) % 4;
        s[4*c+r] = inv ? inv_sub[t[4*src+r]] : fwd_sub[t[4*src+r]];
      end
    end
    return s;
  endfunction

  function automatic blk_t mix_cols(blk_t s, logic inv);
    logic [7:0] coef [4];
    logic [7:0] col [4];
    logic [7:0] acc;
    if (inv) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
    else     coef = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) col[r] = s[4*c+r];
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++) acc ^= gmul(coef[(k - r + 4) % 4], col[k]);
        s[4*c+r] = acc;
      end
    end
    return s;
  endfunction

  function automatic logic [127:0] run_cipher(logic [127:0] blk, logic dec, int nr);
    blk_t s;
    logic [127:0] res;
    for (int k = 0; k < 16; k++) s[k] = blk[127 - 8*k -: 8];
    if (!dec) begin
      s = add_round_key(s, 0);
      for (int i = 1; i < nr; i++) begin
        s = sub_shift(s, 1'b0);
        s = mix_cols(s, 1'b0);
        s = add_round_key(s, i);
      end
      s = sub_shift(s, 1'b0);
      s = add_round_key(s, nr);
    end else begin
      s = add_round_key(s, nr);
      for (int i = 1; i < nr; i++) begin
        s = sub_shift(s, 1'b1);
        s = add_round_key(s, nr - i);
        s = mix_cols(s, 1'b1);
      end
      s = sub_shift(s, 1'b1);
      s = add_round_key(s, 0);
    end
    for (int k = 0; k < 16; k++) res[127 - 8*k -: 8] = s[k];
    return res;
  endfunction

  always @(posedge clk) begin
    cipher_out_t exp_out;
    logic [127:0] res;
    int nr;
    if (!rst_n) begin
      rounds = MIN_ROUNDS;
      cipher_q.delete();
    end else begin
      if (cfg_we) rounds = cfg_data;
      // result beat
      if (out_valid && !out_stall) begin
        if (cipher_q.size() == 0) begin
          $error("unexpected result beat hi=%h lo=%h", out_result_hi, out_result_lo);
          errors++;
        end else begin
          exp_out = cipher_q.pop_front();
          if (out_result_hi !== exp_out.hi) begin
            $error("result_hi expected %h actual %h", exp_out.hi, out_result_hi);
            errors++;
          end
          if (out_result_lo !== exp_out.lo) begin
            $error("result_lo expected %h actual %h", exp_out.lo, out_result_lo);
            errors++;
          end
          if (out_was_decrypt !== exp_out.dec) begin
            $error("was_decrypt expected %b actual %b", exp_out.dec, out_was_decrypt);
            errors++;
          end
        end
      end
      // input beat
      if (in_valid && !in_stall) begin
        case (cmd_t'(in_cmd))
          CMD_LOAD: begin
            if (in_key_word_index < KEY_WORDS) key_mem[in_key_word_index] = in_key_word_value;
          end
          CMD_ENCRYPT, CMD_DECRYPT: begin
            nr = rounds;
            if (nr < MIN_ROUNDS) nr = MIN_ROUNDS;
            if (nr > MAX_ROUNDS) nr = MAX_ROUNDS;
            exp_out.dec = (cmd_t'(in_cmd) == CMD_DECRYPT);
            res = run_cipher({in_block_hi, in_block_lo}, exp_out.dec, nr);
            exp_out.hi = res[127:64];
            exp_out.lo = res[63:0];
            cipher_q.push_back(exp_out);
          end
          default: ;
        endcase
      end
    end
    pending = cipher_q.size();
  end

endmodule

// File: tb/tb_aes_block_cipher_core.sv
`timescale 1ns / 1ps
module tb_aes_block_cipher_core;
  import aes_pkg::*;

  // With random stalls this bound is far above what the slowest beat needs.
  localparam int CYCLE_LIMIT = 1000000;
  // Quiet time after the last result before touching cfg or ending.
  localparam int SETTLE = 20;
  localparam int BEATS_PER_SETTING = 61;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = CMD_NONE;
  logic [5:0]  in_key_word_index = '0;
  logic [31:0] in_key_word_value = '0;
  logic [63:0] in_block_hi = '0;
  logic [63:0] in_block_lo = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_result_hi;
  logic [63:0] out_result_lo;
  logic        out_was_decrypt;

  int errors;
  int pending;
  int cycles = 0;
  int in_idle = 0;   // percent of cycles the sender holds off
  int out_idle = 0;  // percent of cycles the receiver stalls

  // Round settings per phase, out-of-range values included (clamped to 10/14).
  logic [3:0] round_plan [8] = '{4'd10, 4'd0, 4'd12, 4'd15, 4'd11, 4'd13, 4'd14, 4'd9};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  aes_block_cipher_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_key_word_index (in_key_word_index),
    .in_key_word_value (in_key_word_value),
    .in_block_hi       (in_block_hi),
    .in_block_lo       (in_block_lo),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_hi     (out_result_hi),
    .out_result_lo     (out_result_lo),
    .out_was_decrypt   (out_was_decrypt)
  );

  aes_cipher_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_key_word_index (in_key_word_index),
    .in_key_word_value (in_key_word_value),
    .in_block_hi       (in_block_hi),
    .in_block_lo       (in_block_lo),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_hi     (out_result_hi),
    .out_result_lo     (out_result_lo),
    .out_was_decrypt   (out_was_decrypt),
    .errors            (errors),
    .pending           (pending)
  );

  // Receiver: random stall, one update per edge.
  always @(posedge clk) out_stall <= ($urandom_range(99) < out_idle);

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL aes_block_cipher_core");
      $finish;
    end
  end

  // Present one beat and hold it until taken. Valid is only dropped on an
  // idle cycle, so back-to-back beats never see a low/high pair in one step.
  task automatic send_beat(cmd_t cmd, logic [5:0] idx, logic [31:0] kval,
                           logic [63:0] hi, logic [63:0] lo);
    while ($urandom_range(99) < in_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_cmd            <= cmd;
    in_key_word_index <= idx;
    in_key_word_value <= kval;
    in_block_hi       <= hi;
    in_block_lo       <= lo;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold off until every result is back, then let a trailing load settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_rounds(logic [3:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand_half();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic rand_beat();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70)
      send_beat($urandom_range(1) ? CMD_DECRYPT : CMD_ENCRYPT, 6'($urandom), $urandom,
                rand_half(), rand_half());
    else if (pick < 90)
      send_beat(CMD_LOAD, 6'($urandom_range(59)), $urandom, rand_half(), rand_half());
    else if (pick < 95)
      send_beat(CMD_NONE, 6'($urandom), $urandom, rand_half(), rand_half());
    else
      // index past the schedule: must be dropped
      send_beat(CMD_LOAD, 6'($urandom_range(63, 60)), $urandom, rand_half(), rand_half());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole schedule so no block ever reads an unwritten word.
    for (int w = 0; w < 60; w++) send_beat(CMD_LOAD, 6'(w), $urandom, '0, '0);

    // Directed: extremes, both directions, ignored loads and the spare opcode.
    send_beat(CMD_ENCRYPT, '0, '0, '0, '0);
    send_beat(CMD_DECRYPT, '0, '0, '0, '0);
    send_beat(CMD_ENCRYPT, '1, '1, '1, '1);
    send_beat(CMD_DECRYPT, '1, '1, '1, '1);
    send_beat(CMD_ENCRYPT, '0, '0, {32{2'b01}}, {32{2'b10}});
    send_beat(CMD_DECRYPT, '0, '0, {32{2'b10}}, {32{2'b01}});
    send_beat(CMD_LOAD, 6'd63, '1, '1, '1);
    send_beat(CMD_LOAD, 6'd60, 32'h5a5a_a5a5, '0, '0);
    send_beat(CMD_NONE, '1, '1, '1, '1);
    send_beat(CMD_ENCRYPT, '0, '0, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    send_beat(CMD_LOAD, 6'd0, '1, '0, '0);
    send_beat(CMD_LOAD, 6'd59, '0, '0, '0);
    send_beat(CMD_DECRYPT, '0, '0, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    drain();
    set_rounds(4'd0);
    send_beat(CMD_ENCRYPT, '0, '0, '1, '0);
    send_beat(CMD_DECRYPT, '0, '0, '0, '1);
    drain();
    set_rounds(4'd15);
    send_beat(CMD_ENCRYPT, '0, '0, '1, '0);
    send_beat(CMD_DECRYPT, '0, '0, '0, '1);

    // Random: three idle regimes, every round setting in each.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin in_idle = 30; out_idle = 51; end
        1: begin in_idle = 51; out_idle = 30; end
        default: begin in_idle = 0; out_idle = 0; end
      endcase
      for (int p = 0; p < 8; p++) begin
        drain();
        set_rounds(round_plan[(p + 3 * mode) % 8]);
        for (int n = 0; n < BEATS_PER_SETTING; n++) rand_beat();
      end
    end

    drain();
    if (errors == 0 && pending == 0)
      $display("PASS aes_block_cipher_core");
    else
      $display("FAIL aes_block_cipher_core");
    $finish;
  end

endmodule

// File: aes_block_cipher_core.f
hdl/aes_pkg.sv
hdl/aes_round.sv
hdl/aes_key_ram.sv
hdl/aes_block_cipher_core.sv
tb/aes_cipher_checker.sv
tb/tb_aes_block_cipher_core.sv
